[rtl/gcnc_pkg.sv]
// ----------------------------------------------------------------------------
// gcnc_pkg
// Shared types and helpers for the grid cell neighbour classifier: per-cell
// position flags, classification result and per-transfer count increments.
// ----------------------------------------------------------------------------
package gcnc_pkg;

  // width of each result count
  localparam int COUNT_W = 15;

  // position flags of a cell, captured when its transfer is taken
  typedef struct packed {
    logic cur;
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_col;
    logic last_row;
  } issue_t;

  // one-hot class of a single center cell (all zero when not counted)
  typedef struct packed {
    logic isec;
    logic junc;
    logic turn;
    logic endp;
  } class_t;

  // per-cycle increments, up to four classified cells per cycle
  typedef struct packed {
    logic [2:0] isec;
    logic [2:0] junc;
    logic [2:0] turn;
    logic [2:0] endp;
  } inc_t;

  // classify a set center cell by its four orthogonal neighbours
  function automatic class_t classify(input logic center, input logic up,
                                      input logic down, input logic left,
                                      input logic right);
    logic [2:0] nsum;
    class_t     k;
    nsum = 3'(up) + 3'(down) + 3'(left) + 3'(right);
    k    = '0;
    if (center) begin
      case (nsum)
        3'd4:    k.isec = 1'b1;
        3'd3:    k.junc = 1'b1;
        3'd2:    k.turn = !((up && down) || (left && right));
        3'd1:    k.endp = 1'b1;
        default: k = '0;
      endcase
    end
    return k;
  endfunction

endpackage

[rtl/gcnc_line_mem.sv]
// ----------------------------------------------------------------------------
// gcnc_line_mem
// Line buffer memory: one 2-bit word per column holding the cells of the
// two previous rows, {older, recent}. One read and one write port, read data
// registered.
// ----------------------------------------------------------------------------
module gcnc_line_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data
);

  logic [1:0] mem [DEPTH];

  // synchronous read, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // write back of the updated column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[rtl/gcnc_window.sv]
// ----------------------------------------------------------------------------
// gcnc_window
// Execute stage: takes the column word read from the line memory, writes the
// shifted word back, keeps the two previous columns of the 3-row window and
// classifies every cell whose neighbours became known with this cell.
// ----------------------------------------------------------------------------
module gcnc_window #(
  parameter int AW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 issue_valid,
  input  gcnc_pkg::issue_t     issue,
  input  logic [AW-1:0]        issue_col,
  input  logic [1:0]           rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [1:0]           wr_data,
  output logic                 inc_valid,
  output gcnc_pkg::inc_t       inc,
  output logic                 grid_done
);

  logic             s1_valid;
  gcnc_pkg::issue_t s1;
  logic [AW-1:0]    s1_col;

  // previous two columns of the window (already row masked)
  logic o1, m1, c1, m2, c2;

  logic mo, mm;
  logic p_o, p_m, p_c, q_m, q_c;
  gcnc_pkg::class_t ka, kb, kc, kd;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_valid) begin
      s1     <= issue;
      s1_col <= issue_col;
    end
  end

  // cells above: older is two rows up, recent is one row up
  assign mo = rd_data[1] & s1.row_ge2;
  assign mm = rd_data[0] & s1.row_ge1;

  // write back: recent moves to older, current cell becomes recent
  assign wr_en   = s1_valid;
  assign wr_addr = s1_col;
  assign wr_data = {rd_data[0], s1.cur};

  // window shift
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      o1 <= mo;
      m1 <= mm;
      c1 <= s1.cur;
      m2 <= m1;
      c2 <= c1;
    end
  end

  // columns left of the grid read as zero
  assign p_o = o1 & s1.col_ge1;
  assign p_m = m1 & s1.col_ge1;
  assign p_c = c1 & s1.col_ge1;
  assign q_m = m2 & s1.col_ge2;
  assign q_c = c2 & s1.col_ge2;

  // upper-left cell, its right neighbour just came from memory
  assign ka = gcnc_pkg::classify(p_m, p_o, p_c, q_m, mm);
  // upper cell at row end, no right neighbour
  assign kb = s1.last_col ? gcnc_pkg::classify(mm, mo, s1.cur, p_m, 1'b0) : '0;
  // last row: cell to the left, no lower neighbour
  assign kc = s1.last_row ? gcnc_pkg::classify(p_c, p_m, 1'b0, q_c, s1.cur) : '0;
  // very last cell of the grid
  assign kd = (s1.last_row && s1.last_col) ?
              gcnc_pkg::classify(s1.cur, mm, 1'b0, p_c, 1'b0) : '0;

  // per-class increments
  assign inc.isec = 3'(ka.isec) + 3'(kb.isec) + 3'(kc.isec) + 3'(kd.isec);
  assign inc.junc = 3'(ka.junc) + 3'(kb.junc) + 3'(kc.junc) + 3'(kd.junc);
  assign inc.turn = 3'(ka.turn) + 3'(kb.turn) + 3'(kc.turn) + 3'(kd.turn);
  assign inc.endp = 3'(ka.endp) + 3'(kb.endp) + 3'(kc.endp) + 3'(kd.endp);

  assign inc_valid = s1_valid;
  assign grid_done = s1_valid && s1.last_row && s1.last_col;

endmodule

[rtl/gcnc_tally.sv]
// ----------------------------------------------------------------------------
// gcnc_tally
// Saturating class counters and the result buffer: the output register with
// a spare register behind it. The final counts of a grid go to the buffer and
// the counters restart at zero.
// ----------------------------------------------------------------------------
module gcnc_tally (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          inc_valid,
  input  gcnc_pkg::inc_t                inc,
  input  logic                          grid_done,
  output logic                          hold_last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [gcnc_pkg::COUNT_W-1:0]  intersections,
  output logic [gcnc_pkg::COUNT_W-1:0]  junctions,
  output logic [gcnc_pkg::COUNT_W-1:0]  turns,
  output logic [gcnc_pkg::COUNT_W-1:0]  ends
);

  localparam int CW = gcnc_pkg::COUNT_W;
  localparam logic [CW-1:0] CountMax = '1;

  logic [CW-1:0] isec_cnt, junc_cnt, turn_cnt, endp_cnt;
  logic [CW-1:0] isec_next, junc_next, turn_next, endp_next;
  logic          spare_valid;
  logic [CW-1:0] spare_isec, spare_junc, spare_turn, spare_endp;
  logic          out_take;
  logic          out_free;
  logic [1:0]    slots_used;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [2:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    return (s > {1'b0, CountMax}) ? CountMax : s[CW-1:0];
  endfunction

  assign isec_next = sat_add(isec_cnt, inc.isec);
  assign junc_next = sat_add(junc_cnt, inc.junc);
  assign turn_next = sat_add(turn_cnt, inc.turn);
  assign endp_next = sat_add(endp_cnt, inc.endp);

  // running counts
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      isec_cnt <= '0;
      junc_cnt <= '0;
      turn_cnt <= '0;
      endp_cnt <= '0;
    end else if (inc_valid) begin
      if (grid_done) begin
        isec_cnt <= '0;
        junc_cnt <= '0;
        turn_cnt <= '0;
        endp_cnt <= '0;
      end else begin
        isec_cnt <= isec_next;
        junc_cnt <= junc_next;
        turn_cnt <= turn_next;
        endp_cnt <= endp_next;
      end
    end
  end

  // buffer occupancy once this edge is done; a last cell taken now lands after
  // the execute stage register, so it needs at least one slot left over
  assign out_take   = result_valid && !result_stall;
  assign out_free   = !result_valid || !result_stall;
  assign slots_used = 2'(result_valid) + 2'(spare_valid) + 2'(grid_done) - 2'(out_take);
  assign hold_last  = (slots_used > 2'd1);

  // buffer valid flags, the spare only fills behind a held output
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_valid  <= 1'b0;
    end else if (out_free) begin
      result_valid <= spare_valid || grid_done;
      spare_valid  <= spare_valid && grid_done;
    end else if (grid_done) begin
      spare_valid <= 1'b1;
    end
  end

  // output register, from the spare first to keep the order
  always_ff @(posedge clk) begin
    if (out_free && spare_valid) begin
      intersections <= spare_isec;
      junctions     <= spare_junc;
      turns         <= spare_turn;
      ends          <= spare_endp;
    end else if (out_free && grid_done) begin
      intersections <= isec_next;
      junctions     <= junc_next;
      turns         <= turn_next;
      ends          <= endp_next;
    end
  end

  // spare register
  always_ff @(posedge clk) begin
    if (grid_done && (spare_valid || !out_free)) begin
      spare_isec <= isec_next;
      spare_junc <= junc_next;
      spare_turn <= turn_next;
      spare_endp <= endp_next;
    end
  end

endmodule

[rtl/grid_cell_neighbour_classifier_top.sv]
// ----------------------------------------------------------------------------
// grid_cell_neighbour_classifier_top
// Four-neighbour classifier for a square binary grid streamed in raster
// order; counts intersections, junctions, turns and ends per grid.
// ----------------------------------------------------------------------------
// Cells of a grid_side x grid_side grid are taken one per transfer, row by
// row, left to right; neighbours outside the grid count as zero. The block
// takes one cell per clock unless the last cell is held off: each cell costs
// one read and one write of the line memory (read when the cell is taken,
// write back in the following cycle), and a cell is classified once the cell
// below it (or, in the last row, to its right) has arrived. The result
// transfer carries the four saturating counts and is registered once the
// last cell of the grid has passed the execute stage; a spare register behind
// the output holds one more result, and the last cell of a grid is held off
// only while both would still be occupied when its counts land, so even
// one-cell grids run at one cell per clock while results are taken. A write of
// grid_side (0 acts as 1, values above MAX_SIDE act as MAX_SIDE) restarts the
// grid. The line memory needs no clearing pass after reset.
module grid_cell_neighbour_classifier_top #(
  parameter int MAX_SIDE = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          cell_valid,
  output logic                          cell_stall,
  input  logic                          cell_req,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [gcnc_pkg::COUNT_W-1:0]  intersections,
  output logic [gcnc_pkg::COUNT_W-1:0]  junctions,
  output logic [gcnc_pkg::COUNT_W-1:0]  turns,
  output logic [gcnc_pkg::COUNT_W-1:0]  ends
);

  localparam int AW        = $clog2(MAX_SIDE);
  localparam int XW        = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int SideReset = 128;
  localparam logic [AW-1:0] ResetLast =
    AW'(((SideReset > MAX_SIDE) ? MAX_SIDE : SideReset) - 1);
  localparam logic [XW-1:0] MaxSideX = XW'(MAX_SIDE);

  logic [AW-1:0]    side_last;
  logic [AW-1:0]    col;
  logic [AW-1:0]    row;
  logic [XW-1:0]    side_x;
  logic [AW-1:0]    cfg_last;
  logic             in_last;
  logic             accept;
  gcnc_pkg::issue_t issue;
  logic [1:0]       rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [1:0]       wr_data;
  logic             inc_valid;
  gcnc_pkg::inc_t   inc;
  logic             grid_done;
  logic             hold_last;

  // clamp the written side and keep it as the last index
  assign side_x = XW'(cfg_wdata);
  always_comb begin
    if (side_x == '0) begin
      cfg_last = '0;
    end else if (side_x > MaxSideX) begin
      cfg_last = AW'(MaxSideX - XW'(1));
    end else begin
      cfg_last = AW'(side_x - XW'(1));
    end
  end

  // hold off the last cell while the result buffer cannot take its counts
  assign in_last    = (row == side_last) && (col == side_last);
  assign cell_stall = in_last && hold_last;
  assign accept     = cell_valid && !cell_stall;

  // raster position of the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      side_last <= ResetLast;
      col       <= '0;
      row       <= '0;
    end else if (cfg_wen) begin
      side_last <= cfg_last;
      col       <= '0;
      row       <= '0;
    end else if (accept) begin
      if (col == side_last) begin
        col <= '0;
        row <= (row == side_last) ? '0 : row + AW'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // position flags travelling with the cell
  assign issue.cur      = cell_req;
  assign issue.row_ge1  = (row != '0);
  assign issue.row_ge2  = (row > AW'(1));
  assign issue.col_ge1  = (col != '0);
  assign issue.col_ge2  = (col > AW'(1));
  assign issue.last_col = (col == side_last);
  assign issue.last_row = (row == side_last);

  gcnc_line_mem #(
    .DEPTH (MAX_SIDE),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gcnc_window #(
    .AW (AW)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (accept),
    .issue       (issue),
    .issue_col   (col),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .inc_valid   (inc_valid),
    .inc         (inc),
    .grid_done   (grid_done)
  );

  gcnc_tally u_tally (
    .clk           (clk),
    .rst           (rst),
    .clear         (cfg_wen),
    .inc_valid     (inc_valid),
    .inc           (inc),
    .grid_done     (grid_done),
    .hold_last     (hold_last),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .intersections (intersections),
    .junctions     (junctions),
    .turns         (turns),
    .ends          (ends)
  );

`ifndef SYNTHESIS
  // a result only appears right after the last cell of a grid was executed
  a_result_after_grid: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(grid_done))
    else $error("result without a finished grid");

  // only the last cell of a grid is ever held off
  a_stall_only_last: assert property (@(posedge clk) disable iff (rst)
    !in_last |-> !cell_stall)
    else $error("stall on a cell that is not the last of the grid");

  // position stays inside the configured grid
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (col <= side_last) && (row <= side_last))
    else $error("raster position outside the grid");

  // a stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(intersections)))
    else $error("stalled result changed");
`endif

endmodule
